@@ hw/rtl/dms_pkg.sv @@
// ----------------------------------------------------------------------------
// dms_pkg - door motor sequencer shared definitions
// Mode codes, register indexes, payload and state structs.
// ----------------------------------------------------------------------------
package dms_pkg;

  localparam int TimerW = 16;
  localparam int ModeW  = 4;
  localparam int CfgIdxW = 2;

  localparam logic [TimerW-1:0] TimerMax = '1;

  // Mode codes
  localparam logic [ModeW-1:0] MODE_INIT             = 4'd0;
  localparam logic [ModeW-1:0] MODE_CLOSING          = 4'd1;
  localparam logic [ModeW-1:0] MODE_CLOSE_SETTLE     = 4'd2;
  localparam logic [ModeW-1:0] MODE_CLOSED           = 4'd3;
  localparam logic [ModeW-1:0] MODE_OPENING          = 4'd4;
  localparam logic [ModeW-1:0] MODE_OPEN_SETTLE      = 4'd5;
  localparam logic [ModeW-1:0] MODE_OPEN             = 4'd6;
  localparam logic [ModeW-1:0] MODE_MIDCLOSED_SETTLE = 4'd7;
  localparam logic [ModeW-1:0] MODE_MIDCLOSED        = 4'd8;
  localparam logic [ModeW-1:0] MODE_MIDOPEN_SETTLE   = 4'd9;
  localparam logic [ModeW-1:0] MODE_MIDOPEN          = 4'd10;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_START_DELAY    = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG_DELAY     = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_SHORT_DELAY    = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_TRAVEL_TIMEOUT = 2'd3;

  // Register reset values, milliseconds
  localparam logic [TimerW-1:0] START_DELAY_RST    = 16'd5000;
  localparam logic [TimerW-1:0] LONG_DELAY_RST     = 16'd5000;
  localparam logic [TimerW-1:0] SHORT_DELAY_RST    = 16'd2000;
  localparam logic [TimerW-1:0] TRAVEL_TIMEOUT_RST = 16'd30000;

  typedef struct packed {
    logic [7:0] elapsed_ms;
    logic       closed_limit;
    logic       open_limit;
    logic       trigger;
  } dms_in_t;

  typedef struct packed {
    logic [ModeW-1:0] door_state;
    logic             motor_on;
    logic             motor_toward_close;
    logic             state_changed;
  } dms_out_t;

  typedef struct packed {
    logic [TimerW-1:0] start_delay;
    logic [TimerW-1:0] long_delay;
    logic [TimerW-1:0] short_delay;
    logic [TimerW-1:0] travel_timeout;
  } dms_cfg_t;

  typedef struct packed {
    logic [ModeW-1:0]  mode;
    logic [TimerW-1:0] delay_timer;
    logic [TimerW-1:0] travel_timer;
    logic              relay_active;
    logic              relay_direction;
  } dms_state_t;

endpackage

@@ hw/rtl/dms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// dms_cfg_regs - configuration register file
// Four 16-bit millisecond registers behind a plain write port.
// ----------------------------------------------------------------------------
module dms_cfg_regs
  import dms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimerW-1:0]  cfg_data,
  output dms_cfg_t           cfg
);

  // Load the addressed register, restore defaults on reset
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_delay    <= START_DELAY_RST;
      cfg.long_delay     <= LONG_DELAY_RST;
      cfg.short_delay    <= SHORT_DELAY_RST;
      cfg.travel_timeout <= TRAVEL_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_START_DELAY:    cfg.start_delay    <= cfg_data;
        REG_LONG_DELAY:     cfg.long_delay     <= cfg_data;
        REG_SHORT_DELAY:    cfg.short_delay    <= cfg_data;
        REG_TRAVEL_TIMEOUT: cfg.travel_timeout <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ hw/rtl/dms_step.sv @@
// ----------------------------------------------------------------------------
// dms_step - one service tick of the sequencer
// Saturating timer update followed by one mode transition.
// ----------------------------------------------------------------------------
module dms_step
  import dms_pkg::*;
(
  input  dms_state_t state,
  input  dms_cfg_t   cfg,
  input  dms_in_t    req,
  output dms_state_t state_next,
  output dms_out_t   result
);

  logic [TimerW:0]   delay_sum;
  logic [TimerW:0]   travel_sum;
  logic [TimerW-1:0] delay_acc;
  logic [TimerW-1:0] travel_acc;
  logic              stop_cond;

  // Add elapsed time, saturate at full scale
  always_comb begin
    delay_sum  = {1'b0, state.delay_timer} + {{(TimerW-7){1'b0}}, req.elapsed_ms};
    travel_sum = {1'b0, state.travel_timer} + {{(TimerW-7){1'b0}}, req.elapsed_ms};
    delay_acc  = delay_sum[TimerW] ? TimerMax : delay_sum[TimerW-1:0];
    travel_acc = travel_sum[TimerW] ? TimerMax : travel_sum[TimerW-1:0];
    stop_cond  = req.trigger || (travel_acc >= cfg.travel_timeout);
  end

  // Mode transition
  always_comb begin
    state_next              = state;
    state_next.delay_timer  = delay_acc;
    state_next.travel_timer = travel_acc;
    unique case (state.mode)
      MODE_CLOSING, MODE_OPENING: begin
        if ((state.mode == MODE_CLOSING) ? req.closed_limit : req.open_limit) begin
          state_next.mode = (state.mode == MODE_CLOSING) ? MODE_CLOSE_SETTLE
                                                         : MODE_OPEN_SETTLE;
        end else if (stop_cond) begin
          state_next.mode = (state.mode == MODE_CLOSING) ? MODE_MIDCLOSED_SETTLE
                                                         : MODE_MIDOPEN_SETTLE;
        end
        // Drop the relay on any stop
        if (state_next.mode != state.mode) begin
          state_next.delay_timer     = '0;
          state_next.relay_active    = 1'b0;
          state_next.relay_direction = 1'b0;
        end
      end
      MODE_CLOSE_SETTLE: begin
        if (delay_acc >= cfg.long_delay) state_next.mode = MODE_CLOSED;
      end
      MODE_OPEN_SETTLE: begin
        if (delay_acc >= cfg.long_delay) state_next.mode = MODE_OPEN;
      end
      MODE_MIDCLOSED_SETTLE: begin
        if (delay_acc >= cfg.short_delay) state_next.mode = MODE_MIDCLOSED;
      end
      MODE_MIDOPEN_SETTLE: begin
        if (delay_acc >= cfg.short_delay) state_next.mode = MODE_MIDOPEN;
      end
      MODE_OPEN, MODE_MIDOPEN, MODE_CLOSED, MODE_MIDCLOSED: begin
        // Start the motor toward the far end
        if (req.trigger) begin
          state_next.delay_timer     = '0;
          state_next.travel_timer    = '0;
          state_next.relay_active    = 1'b1;
          state_next.relay_direction = (state.mode == MODE_OPEN) ||
                                       (state.mode == MODE_MIDOPEN);
          state_next.mode            = state_next.relay_direction ? MODE_CLOSING
                                                                  : MODE_OPENING;
        end
      end
      default: begin
        // Init and unused codes: sample the limits once the start delay is up
        state_next.mode = MODE_INIT;
        if (delay_acc >= cfg.start_delay) begin
          state_next.delay_timer = '0;
          if (req.closed_limit)    state_next.mode = MODE_CLOSED;
          else if (req.open_limit) state_next.mode = MODE_OPEN;
          else                     state_next.mode = MODE_MIDCLOSED;
        end
      end
    endcase
  end

  // Result taken after the transition
  always_comb begin
    result.door_state         = state_next.mode;
    result.motor_on           = state_next.relay_active;
    result.motor_toward_close = state_next.relay_direction;
    result.state_changed      = (state_next.mode != state.mode);
  end

endmodule

@@ hw/rtl/door_motor_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// door_motor_sequencer_unit - single-button door motor sequencer
//
//   channel  direction  handshake            payload
//   in       request    in_valid/in_ready    in_data   (dms_in_t)
//   out      result     out_valid/out_ready  out_data  (dms_out_t)
//   cfg      write      cfg_we               cfg_index, cfg_data
//
// One request per cycle sustained while out_ready holds; each accepted request
// reaches out_data through the input register, then the result register.
// The mode/timer registers update in the same cycle the input register hands
// its request to the result register, so the loop through dms_step sets rate.
// A stalled output holds the input register; in_ready drops only when both hold.
// Synchronous reset returns mode to init, timers to zero, relay off and
// registers to their defaults. No clearing pass.
// ----------------------------------------------------------------------------
module door_motor_sequencer_unit
  import dms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  dms_in_t            in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dms_out_t           out_data,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [TimerW-1:0]  cfg_data
);

  dms_cfg_t   cfg;
  dms_state_t state;
  dms_state_t state_next;
  dms_out_t   result;
  dms_in_t    req;
  logic       req_valid;
  logic       advance;

  dms_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  dms_step u_step (
    .state      (state),
    .cfg        (cfg),
    .req        (req),
    .state_next (state_next),
    .result     (result)
  );

  // Handshake: advance when the result register is free or being drained
  assign advance  = req_valid && (!out_valid || out_ready);
  assign in_ready = !req_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      req <= in_data;
    end
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode            <= MODE_INIT;
      state.delay_timer     <= '0;
      state.travel_timer    <= '0;
      state.relay_active    <= 1'b0;
      state.relay_direction <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

`ifndef SYNTHESIS
  // Motor runs only in a travel mode
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.motor_on |->
      (out_data.door_state == MODE_CLOSING || out_data.door_state == MODE_OPENING))
    else $error("motor on outside travel mode");

  // Direction is cleared whenever the relay is off
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.motor_on |-> !out_data.motor_toward_close)
    else $error("direction set with relay off");

  // Registered result mirrors the committed mode
  assert property (@(posedge clk) disable iff (rst)
    advance |=> out_data.door_state == state.mode)
    else $error("result mode differs from state");

  // Only defined mode codes are ever reached
  assert property (@(posedge clk) disable iff (rst)
    state.mode <= MODE_MIDOPEN)
    else $error("mode code out of range");

  // Mode is held while no request advances
  assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state.mode))
    else $error("mode changed without a request");
`endif

endmodule
